// File: design/ncils_pkg.sv
// ncils_pkg: shared types and constants for the nearest car in lane selector
// field widths, register map, reset values and the beat structs
// no dependencies
package ncils_pkg;

  // field widths
  localparam int unsigned CarDW     = 16;
  localparam int unsigned CarSW     = 24;
  localparam int unsigned LaneW     = 3;
  localparam int unsigned IndexW    = 6;
  localparam int unsigned LaneWidthW = 16;

  // packed stream widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 16;

  // configuration register map (register index taken from paddr[2])
  localparam logic RegLaneWidth     = 1'b0;
  localparam logic RegRightmostLane = 1'b1;

  // reset values of the configuration registers
  localparam logic [LaneWidthW-1:0] LaneWidthRst     = 16'd1024;
  localparam logic [LaneW-1:0]      RightmostLaneRst = 3'd2;

  // one input beat, car_d in the lowest bits
  typedef struct packed {
    logic                    last_car;
    logic [LaneW-1:0]        target_lane;
    logic [CarSW-1:0]        own_s;
    logic [CarSW-1:0]        car_s;
    logic signed [CarDW-1:0] car_d;
  } car_item_t;

  // one result beat, front_found in the lowest bit
  typedef struct packed {
    logic [IndexW-1:0] rear_index;
    logic              rear_found;
    logic [IndexW-1:0] front_index;
    logic              front_found;
  } scan_result_t;

endpackage

// File: design/ncils_lane_match.sv
// ncils_lane_match: decides whether a car's lateral position falls in the target lane
// compares against the lane's lower and upper edge instead of dividing
// depends on ncils_pkg
module ncils_lane_match
  import ncils_pkg::*;
#(
  parameter int unsigned LANE_LIMIT = 8
) (
  input  logic [LaneWidthW-1:0] lane_span_i,
  input  logic [LaneW-1:0]      last_lane_i,
  input  logic signed [CarDW-1:0] car_d_i,
  input  logic [LaneW-1:0]      target_lane_i,
  output logic                  match_o
);

  localparam logic [3:0] TopLimit = 4'(LANE_LIMIT - 1);

  logic [LaneWidthW-1:0] width_eff;
  logic [3:0]            top_lane;
  logic [3:0]            tl_ext;
  logic [18:0]           edge_lo;
  logic [19:0]           edge_hi;
  logic [19:0]           d_ext;
  logic                  tl_in_range;

  // zero width behaves as width one
  assign width_eff = (lane_span_i == '0) ? LaneWidthW'(1) : lane_span_i;

  // highest lane, limited by the lane count
  assign top_lane = ({1'b0, last_lane_i} > TopLimit) ? TopLimit
                                                     : {1'b0, last_lane_i};
  assign tl_ext      = {1'b0, target_lane_i};
  assign tl_in_range = (tl_ext <= top_lane);

  // lane edges: tl*w and (tl+1)*w
  assign edge_lo = 19'(target_lane_i) * 19'(width_eff);
  assign edge_hi = 20'(edge_lo) + 20'(width_eff);
  assign d_ext   = 20'(car_d_i[CarDW-2:0]);

  // negative positions land in lane zero, the top lane takes everything above
  always_comb begin
    if (!tl_in_range) begin
      match_o = 1'b0;
    end else if (car_d_i[CarDW-1]) begin
      match_o = (target_lane_i == '0);
    end else begin
      match_o = (d_ext >= 20'(edge_lo)) && ((tl_ext == top_lane) || (d_ext < edge_hi));
    end
  end

endmodule

// File: design/ncils_track.sv
// ncils_track: scan position counter and nearest ahead / behind trackers
// gives the result including the current car, clears on the last car
// depends on ncils_pkg
module ncils_track
  import ncils_pkg::*;
#(
  parameter int unsigned MAX_CARS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         adv_i,
  input  car_item_t    item_i,
  input  logic         match_i,
  output scan_result_t result_o
);

  localparam int unsigned PosW = $clog2(MAX_CARS);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_CARS - 1);

  logic [PosW-1:0]  pos_q;
  logic             ahead_valid_q, ahead_valid_d;
  logic [PosW-1:0]  ahead_pos_q, ahead_pos_d;
  logic [CarSW-1:0] ahead_gap_q, ahead_gap_d;
  logic             behind_valid_q, behind_valid_d;
  logic [PosW-1:0]  behind_pos_q, behind_pos_d;
  logic [CarSW-1:0] behind_gap_q, behind_gap_d;

  logic [CarSW-1:0] gap_a, gap_b;
  logic             take_a, take_b;

  // candidate gaps and strict improvement checks
  assign gap_a  = item_i.car_s - item_i.own_s;
  assign gap_b  = item_i.own_s - item_i.car_s;
  assign take_a = match_i && (item_i.car_s >= item_i.own_s) &&
                  (!ahead_valid_q || (gap_a < ahead_gap_q));
  assign take_b = match_i && (item_i.car_s <= item_i.own_s) &&
                  (!behind_valid_q || (gap_b < behind_gap_q));

  assign ahead_valid_d  = ahead_valid_q | take_a;
  assign ahead_pos_d    = take_a ? pos_q : ahead_pos_q;
  assign ahead_gap_d    = take_a ? gap_a : ahead_gap_q;
  assign behind_valid_d = behind_valid_q | take_b;
  assign behind_pos_d   = take_b ? pos_q : behind_pos_q;
  assign behind_gap_d   = take_b ? gap_b : behind_gap_q;

  // result as seen after this car
  always_comb begin
    result_o.front_found = ahead_valid_d;
    result_o.front_index = ahead_valid_d ? IndexW'(ahead_pos_d) : '0;
    result_o.rear_found  = behind_valid_d;
    result_o.rear_index  = behind_valid_d ? IndexW'(behind_pos_d) : '0;
  end

  // tracker state, cleared at the end of each scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      ahead_valid_q  <= 1'b0;
      ahead_pos_q    <= '0;
      ahead_gap_q    <= '0;
      behind_valid_q <= 1'b0;
      behind_pos_q   <= '0;
      behind_gap_q   <= '0;
    end else if (adv_i) begin
      if (item_i.last_car) begin
        pos_q          <= '0;
        ahead_valid_q  <= 1'b0;
        ahead_pos_q    <= '0;
        ahead_gap_q    <= '0;
        behind_valid_q <= 1'b0;
        behind_pos_q   <= '0;
        behind_gap_q   <= '0;
      end else begin
        pos_q          <= (pos_q == PosMax) ? pos_q : pos_q + PosW'(1);
        ahead_valid_q  <= ahead_valid_d;
        ahead_pos_q    <= ahead_pos_d;
        ahead_gap_q    <= ahead_gap_d;
        behind_valid_q <= behind_valid_d;
        behind_pos_q   <= behind_pos_d;
        behind_gap_q   <= behind_gap_d;
      end
    end
  end

endmodule

// File: design/nearest_car_in_lane_select.sv
// Nearest car in lane selector. Peer cars stream in one per beat; each beat is
// registered, its lane is found by comparing the lateral position with the
// target lane's edges, and the nearest car ahead and behind in that lane are
// tracked by scan position (ties go to the earlier car). The beat marked with
// tlast produces one result beat and starts a new scan. One car is accepted
// every cycle unless a last car waits in the input register, which it does
// only while the previous result is still held on m_axis. The rate is set by
// the single tracker update stage behind the input register; the result
// register follows it. Configuration goes through the APB port.
// depends on ncils_pkg, ncils_lane_match, ncils_track
module nearest_car_in_lane_select
  import ncils_pkg::*;
#(
  parameter int unsigned MAX_CARS   = 64,
  parameter int unsigned LANE_LIMIT = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input cars
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // car_d [15:0], car_s [39:16], own_s [63:40], target_lane [66:64], zero [71:67]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tlast_i,
  // results
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // front_found [0], front_index [6:1], rear_found [7], rear_index [13:8], zero [15:14]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [LaneWidthW-1:0] lane_span_q;
  logic [LaneW-1:0]      last_lane_q;

  logic         in_valid_q;
  car_item_t    in_item_q;
  logic         out_valid_q;
  scan_result_t out_data_q;

  logic         out_free;
  logic         adv;
  logic         in_fire;
  logic         match;
  scan_result_t result;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_span_q <= LaneWidthRst;
      last_lane_q <= RightmostLaneRst;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        RegLaneWidth:     lane_span_q <= pwdata[LaneWidthW-1:0];
        RegRightmostLane: last_lane_q <= pwdata[LaneW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegLaneWidth:     prdata = 32'(lane_span_q);
      RegRightmostLane: prdata = 32'(last_lane_q);
      default:          prdata = '0;
    endcase
  end

  // handshake: a registered car moves on unless it is last and the result slot is busy
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign adv             = in_valid_q && (!in_item_q.last_car || out_free);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= {s_axis_tlast_i, s_axis_tdata_i[66:0]};
    end
  end

  ncils_lane_match #(
    .LANE_LIMIT(LANE_LIMIT)
  ) u_lane_match (
    .lane_span_i  (lane_span_q),
    .last_lane_i  (last_lane_q),
    .car_d_i      (in_item_q.car_d),
    .target_lane_i(in_item_q.target_lane),
    .match_o      (match)
  );

  ncils_track #(
    .MAX_CARS(MAX_CARS)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (in_item_q),
    .match_i (match),
    .result_o(result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_item_q.last_car) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_item_q.last_car) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_data_q};

endmodule

// File: tb/sv/lane_select_checker.sv
`timescale 1ns / 1ps
// lane_select_checker: watches the apb port and both streams of nearest_car_in_lane_select,
// keeps its own copy of the lane registers and scan state, and checks every result beat
// depends on ncils_pkg
module lane_select_checker
  import ncils_pkg::*;
#(
  parameter int unsigned MaxCars   = 64,
  parameter int unsigned LaneLimit = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  input  logic [31:0]         prdata_i,
  input  logic                pready_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tlast_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  mismatches_o,
  output int                  outstanding_o,
  output int                  cars_o,
  output int                  results_o
);

  // register copies
  logic [LaneWidthW-1:0] lane_span;
  logic [LaneW-1:0]      rightmost;

  // scan state
  int unsigned      scan_pos;
  logic             ahead_ok;
  int unsigned      ahead_pos;
  logic [CarSW-1:0] ahead_gap;
  logic             behind_ok;
  int unsigned      behind_pos;
  logic [CarSW-1:0] behind_gap;

  // results predicted but not yet seen on the output
  scan_result_t due_results[$];

  // lane of a lateral position, floor division clamped to 0..rightmost lane
  function automatic int unsigned lane_of(logic signed [CarDW-1:0] d);
    int unsigned w;
    int unsigned top;
    int unsigned lane;
    w = (lane_span == '0) ? 1 : 32'(lane_span);
    top = (32'(rightmost) > LaneLimit - 1) ? LaneLimit - 1 : 32'(rightmost);
    if (d < 0) return 0;
    lane = 32'(d[CarDW-2:0]) / w;
    return (lane > top) ? top : lane;
  endfunction

  task automatic clear_scan();
    scan_pos   = 0;
    ahead_ok   = 1'b0;
    ahead_pos  = 0;
    ahead_gap  = '0;
    behind_ok  = 1'b0;
    behind_pos = 0;
    behind_gap = '0;
  endtask

  // nearest car ahead and behind, strict less-than so the earliest car keeps a tie
  task automatic track_car(car_item_t c);
    logic [CarSW-1:0] gap;
    int unsigned      pos;
    scan_result_t     r;
    pos = scan_pos;
    if (lane_of(c.car_d) == 32'(c.target_lane)) begin
      if (c.car_s >= c.own_s) begin
        gap = c.car_s - c.own_s;
        if (!ahead_ok || gap < ahead_gap) begin
          ahead_ok  = 1'b1;
          ahead_pos = pos;
          ahead_gap = gap;
        end
      end
      if (c.car_s <= c.own_s) begin
        gap = c.own_s - c.car_s;
        if (!behind_ok || gap < behind_gap) begin
          behind_ok  = 1'b1;
          behind_pos = pos;
          behind_gap = gap;
        end
      end
    end
    if (scan_pos < MaxCars - 1) scan_pos++;
    if (c.last_car) begin
      r = '0;
      r.front_found = ahead_ok;
      r.front_index = ahead_ok ? ahead_pos[IndexW-1:0] : '0;
      r.rear_found  = behind_ok;
      r.rear_index  = behind_ok ? behind_pos[IndexW-1:0] : '0;
      due_results = {due_results, r};
      clear_scan();
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    car_item_t    c;
    scan_result_t got;
    scan_result_t want;
    if (!rst_ni) begin
      lane_span = LaneWidthRst;
      rightmost = RightmostLaneRst;
      clear_scan();
      due_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      cars_o        = 0;
      results_o     = 0;
    end else begin
      // register writes and read-back
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == RegLaneWidth) lane_span = pwdata_i[LaneWidthW-1:0];
          else rightmost = pwdata_i[LaneW-1:0];
        end else if (paddr_i[2] == RegLaneWidth) begin
          if (prdata_i[LaneWidthW-1:0] != lane_span)
            report_mismatch("lane span read", int'(prdata_i[LaneWidthW-1:0]),
                            int'(lane_span));
        end else if (prdata_i[LaneW-1:0] != rightmost) begin
          report_mismatch("last lane read", int'(prdata_i[LaneW-1:0]), int'(rightmost));
        end
      end

      // result beat, compared before this edge's car can add a new expectation
      if (m_tvalid_i && m_tready_i) begin
        got = scan_result_t'(m_tdata_i[$bits(scan_result_t)-1:0]);
        results_o++;
        if (due_results.size() == 0) begin
          report_mismatch("result beat with none expected", int'(got), 0);
        end else begin
          want = due_results.pop_front();
          if (got.front_found != want.front_found)
            report_mismatch("front_found", int'(got.front_found), int'(want.front_found));
          if (got.front_index != want.front_index)
            report_mismatch("front_index", int'(got.front_index), int'(want.front_index));
          if (got.rear_found != want.rear_found)
            report_mismatch("rear_found", int'(got.rear_found), int'(want.rear_found));
          if (got.rear_index != want.rear_index)
            report_mismatch("rear_index", int'(got.rear_index), int'(want.rear_index));
        end
      end

      // car beat
      if (s_tvalid_i && s_tready_i) begin
        c.car_d       = s_tdata_i[CarDW-1:0];
        c.car_s       = s_tdata_i[CarDW +: CarSW];
        c.own_s       = s_tdata_i[CarDW+CarSW +: CarSW];
        c.target_lane = s_tdata_i[CarDW+2*CarSW +: LaneW];
        c.last_car    = s_tlast_i;
        track_car(c);
        cars_o++;
      end
      outstanding_o = due_results.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives scans of peer cars and lane settings into nearest_car_in_lane_select
// and gives the verdict; depends on ncils_pkg, the block and lane_select_checker
module tb_top;
  import ncils_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned MaxCars     = 64;

  typedef enum logic [1:0] {RxOpen, RxChoppy, RxSparse} rx_mode_e;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [2:0]          paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int cars_seen;
  int results_seen;

  // lane settings as last written, used to aim cars at the target lane
  logic [LaneWidthW-1:0] cfg_width = LaneWidthRst;
  logic [LaneW-1:0]      cfg_right = RightmostLaneRst;

  int          burst_left    = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  int          settings_run  = 1;
  int unsigned cycles        = 0;
  rx_mode_e    rx_mode       = RxOpen;
  int          rx_left       = 0;

  nearest_car_in_lane_select dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  lane_select_checker scan_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tlast_i     (s_tlast),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .cars_o        (cars_seen),
    .results_o     (results_seen)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: runs of open, choppy and sparse acceptance, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        rx_left = $urandom_range(5, 60);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
        RxOpen: begin
          m_tready <= 1'b1;
        end
        RxChoppy: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_tready <= ($urandom_range(0, 4) == 0);
        end
      endcase
    end
  end

  // one apb transfer, setup then access, then psel and penable drop
  task automatic apb_access(logic wr, logic idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid, wait for every result and let the pipeline drain
  task automatic settle();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // new lane settings, junk in the unused upper bits, then read both back
  task automatic set_lanes(logic [LaneWidthW-1:0] w, logic [LaneW-1:0] r);
    settle();
    apb_access(1'b1, RegLaneWidth, ($urandom() & 32'hFFFF0000) | 32'(w));
    apb_access(1'b1, RegRightmostLane, ($urandom() & 32'hFFFFFFF8) | 32'(r));
    apb_access(1'b0, RegLaneWidth, '0);
    apb_access(1'b0, RegRightmostLane, '0);
    cfg_width    = w;
    cfg_right    = r;
    settings_run = settings_run + 1;
  endtask

  // one car beat; bursts of random length separated by random gaps
  task automatic send_car(car_item_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    s_tdata  <= {{(InDataW-CarDW-2*CarSW-LaneW){1'b0}},
                 c.target_lane, c.own_s, c.car_s, c.car_d};
    s_tlast  <= c.last_car;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic car_item_t directed_car(int d, int s, int own, int tl, logic last);
    car_item_t c;
    c.car_d       = 16'(d);
    c.car_s       = 24'(s);
    c.own_s       = 24'(own);
    c.target_lane = 3'(tl);
    c.last_car    = last;
    return c;
  endfunction

  // random car, mostly in the target lane and near own_s so that gaps tie often
  function automatic car_item_t make_car(logic [LaneW-1:0] tl, logic [CarSW-1:0] own,
                                         logic last);
    car_item_t c;
    longint    lo;
    longint    hi;
    longint    s;
    longint    w;
    w = (cfg_width == 0) ? 1 : cfg_width;
    c.target_lane = tl;
    c.own_s       = own;
    c.last_car    = last;
    lo = longint'(tl) * w;
    if ($urandom_range(0, 9) < 7 && lo <= 32767 && tl <= cfg_right) begin
      hi = (tl == cfg_right) ? 32767 : lo + w - 1;
      if (hi > 32767) hi = 32767;
      if (tl == 0 && $urandom_range(0, 3) == 0) c.car_d = 16'($urandom_range(32768, 65535));
      else c.car_d = 16'($urandom_range(int'(lo), int'(hi)));
    end else begin
      c.car_d = 16'($urandom());
    end
    case ($urandom_range(0, 3))
      0: s = own;
      1: s = longint'(own) + (($urandom_range(0, 1) == 1) ? 1 : -1) *
             longint'($urandom_range(1, 3));
      2: s = longint'(own) + longint'($urandom_range(0, 4000)) - 2000;
      default: s = longint'($urandom_range(0, 24'hFFFFFF));
    endcase
    if (s < 0) s = 0;
    if (s > 24'hFFFFFF) s = 24'hFFFFFF;
    c.car_s = s[CarSW-1:0];
    return c;
  endfunction

  // well-formed scans with random content, a few stray cars that change lane or own_s
  task automatic run_scans(int budget, int longest);
    int                sent;
    int                len;
    logic [LaneW-1:0]  tl;
    logic [CarSW-1:0]  own;
    car_item_t         c;
    sent = 0;
    while (sent < budget) begin
      tl = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                       : 3'($urandom_range(0, cfg_right));
      case ($urandom_range(0, 9))
        0: own = '0;
        1: own = '1;
        default: own = 24'($urandom());
      endcase
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, longest) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        c = make_car(tl, own, i == len - 1);
        if ($urandom_range(0, 19) == 0) begin
          c.target_lane = 3'($urandom());
          c.own_s       = 24'($urandom());
        end
        send_car(c);
      end
      sent += len;
    end
  endtask

  // short directed scans under the reset lane settings (1024 wide, lanes 0..2)
  task automatic directed();
    // lane one: exact own_s counts both ways, a tie keeps the earlier car
    send_car(directed_car(-32768, 1000, 1000, 1, 1'b0));
    send_car(directed_car(1024, 1000, 1000, 1, 1'b0));
    send_car(directed_car(2047, 1500, 1000, 1, 1'b0));
    send_car(directed_car(1500, 1000, 1000, 1, 1'b0));
    send_car(directed_car(1100, 0, 1000, 1, 1'b0));
    send_car(directed_car(32767, 16777215, 1000, 1, 1'b1));
    // top lane at the far end of the road, nothing ahead
    send_car(directed_car(32767, 16777200, 16777215, 2, 1'b0));
    send_car(directed_car(2048, 0, 16777215, 2, 1'b0));
    send_car(directed_car(3071, 16777214, 16777215, 2, 1'b1));
    // negative lateral position lands in lane zero
    send_car(directed_car(-1, 0, 0, 0, 1'b0));
    send_car(directed_car(0, 16777215, 0, 0, 1'b0));
    send_car(directed_car(1023, 5, 0, 0, 1'b1));
    // target past the rightmost lane finds nothing
    send_car(directed_car(32767, 100, 100, 7, 1'b1));
    // single car in another lane
    send_car(directed_car(0, 500, 500, 1, 1'b1));
    // clamped wide positions, ahead tie then a car behind
    send_car(directed_car(2048, 600, 500, 2, 1'b0));
    send_car(directed_car(4000, 550, 500, 2, 1'b0));
    send_car(directed_car(5000, 550, 500, 2, 1'b0));
    send_car(directed_car(30000, 400, 500, 2, 1'b1));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed();
    run_scans(100, 40);

    // narrowest and widest lanes with the extreme rightmost lanes, then zero and 4096 wide lanes
    set_lanes(16'd1, 3'd7);
    run_scans(150, 90);
    set_lanes(16'hFFFF, 3'd0);
    run_scans(120, 30);
    set_lanes(16'd0, 3'd3);
    run_scans(120, 30);
    set_lanes(16'd4096, 3'd7);
    run_scans(150, 90);

    // long receiver hold-off while cars keep coming
    set_lanes(16'd300, 3'd5);
    hold_requests = hold_requests + 1;
    run_scans(150, 30);

    repeat (4) begin
      set_lanes(($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 16))
                                            : 16'($urandom_range(256, 8192)),
                3'($urandom_range(0, 7)));
      run_scans(110, 70);
    end

    settle();
    $display("covered %0d cars and %0d scan results over %0d lane settings",
             cars_seen, results_seen, settings_run);
    $display("scans ran past %0d cars and the receiver held off once for %0d cycles",
             MaxCars, HoldCycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
